@@ rtl/tcle_pkg.sv @@
`timescale 1ns / 1ps
package tcle_pkg;
    localparam int unsigned COLUMNS_PER_ROW = 80;
    localparam int unsigned ROWS_PER_SCREEN = 25;
    localparam int unsigned LINE_MAX        = 64;
    localparam int unsigned TOTAL_CELLS     = COLUMNS_PER_ROW * ROWS_PER_SCREEN;
    localparam int unsigned CELL_W          = $clog2(TOTAL_CELLS);
    localparam int unsigned COL_W           = $clog2(COLUMNS_PER_ROW);
    localparam int unsigned LINE_IDX_W      = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int unsigned COUNT_W         = 7;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NOREQ  = 2'd2;
    localparam logic [1:0] ST_LINE   = 2'd3;

    localparam logic [7:0] KEY_NL  = 8'd10;
    localparam logic [7:0] KEY_DEL = 8'd127;
    localparam logic [7:0] KEY_LO  = 8'h20;
    localparam logic [7:0] KEY_HI  = 8'h7e;
    localparam logic [7:0] ATTR_N  = 8'h07;

    // classified operations handed from front to back
    typedef enum logic [2:0] {
        OP_REPLY,   // single result, no screen work
        OP_BEGIN,   // mark cursor, reply done
        OP_PUT,     // put one cell (char or write cmd)
        OP_NEWLINE, // zero-fill to row end
        OP_DELETE,  // clear previous cell
        OP_READ     // read one cell
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  status;
        logic [15:0] value;
        logic [CELL_W-1:0] index;
        logic        flush;          // emit stored line after the screen work
        logic [COUNT_W-1:0] flush_n; // characters to emit
    } t_job;
endpackage

@@ rtl/tcle_front.sv @@
`timescale 1ns / 1ps
module tcle_front
    import tcle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_key_code,
    input  logic [6:0] i_request_size,
    input  logic [7:0] i_cell_char,
    input  logic [7:0] i_cell_attr,
    input  logic [10:0] i_cell_index,
    output logic o_job_valid,
    input  logic i_job_ready,
    output t_job o_job,
    output logic [7:0] o_line_store [LINE_MAX]
);
    logic r_busy, n_busy;
    logic [COUNT_W-1:0] r_count, n_count, r_limit, n_limit;
    logic [7:0] r_line [LINE_MAX];
    logic r_q_valid;
    t_job r_q, n_q;
    logic take, printable, store;

    assign o_ready     = !r_q_valid || i_job_ready;
    assign take        = i_valid && o_ready;
    assign o_job_valid = r_q_valid;
    assign o_job       = r_q;
    assign o_line_store = r_line;
    assign printable   = (i_key_code >= KEY_LO && i_key_code <= KEY_HI) || i_key_code == KEY_NL;
    assign store       = i_cmd == CMD_KEY && r_busy && printable
                         && r_count < COUNT_W'(LINE_MAX);

    // classify the item and update line state
    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_limit = r_limit;
        n_q     = '0;
        n_q.op  = OP_REPLY;
        n_q.status = ST_DONE;
        n_q.index  = CELL_W'(i_cell_index);
        unique case (i_cmd)
            CMD_BEGIN: begin
                if (r_busy || i_request_size == '0 || i_request_size > COUNT_W'(LINE_MAX)) begin
                    n_q.status = ST_REJECT;
                end else begin
                    n_q.op  = OP_BEGIN;
                    n_busy  = 1'b1;
                    n_limit = i_request_size;
                    n_count = '0;
                end
            end
            CMD_KEY: begin
                if (!r_busy) begin
                    n_q.status = ST_NOREQ;
                end else begin
                    if (printable) begin
                        if (store) n_count = r_count + 1'b1;
                        n_q.op    = (i_key_code == KEY_NL) ? OP_NEWLINE : OP_PUT;
                        n_q.value = {ATTR_N, i_key_code};
                    end else if (i_key_code == KEY_DEL && r_count != '0) begin
                        n_count = r_count - 1'b1;
                        n_q.op  = OP_DELETE;
                    end
                    if (i_key_code == KEY_NL || n_count >= r_limit) begin
                        n_busy = 1'b0;
                        n_q.flush   = n_count != '0;
                        n_q.flush_n = n_count;
                        n_count = '0;
                    end
                end
            end
            CMD_WRITE: begin
                n_q.op    = OP_PUT;
                n_q.value = {i_cell_attr, i_cell_char};
            end
            default: begin
                n_q.op = (i_cell_index < 11'(TOTAL_CELLS)) ? OP_READ : OP_REPLY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_limit   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy  <= n_busy;
                r_count <= n_count;
                r_limit <= n_limit;
            end
            if (take) r_q_valid <= 1'b1;
            else if (i_job_ready) r_q_valid <= 1'b0;
        end
        if (take) r_q <= n_q;
        if (take && store) r_line[r_count[LINE_IDX_W-1:0]] <= i_key_code;
    end
endmodule

@@ rtl/tcle_back.sv @@
`timescale 1ns / 1ps
module tcle_back
    import tcle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    output logic o_job_ready,
    input  t_job i_job,
    input  logic [7:0] i_line_store [LINE_MAX],
    input  logic [13:0] i_screen_base,
    output logic o_valid,
    input  logic i_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_line_char,
    output logic o_last,
    output logic [14:0] o_cursor_address,
    output logic [15:0] o_cell_value
);
    typedef enum logic [3:0] {
        S_IDLE, S_MARK_RD, S_MARK_WR, S_SCR_RD, S_SCR_WR, S_CLR,
        S_FILL, S_DEL, S_READ_RD, S_READ_WAIT, S_EMIT, S_OUT
    } t_state;

    logic [15:0] r_mem [TOTAL_CELLS];
    logic [15:0] r_rd;
    t_state r_state;
    t_job r_job;
    logic [CELL_W-1:0] r_cur, r_pos, r_ptr, r_end;
    logic [COL_W-1:0] r_col;
    logic [COUNT_W-1:0] r_emit;
    logic r_out_valid;
    logic [1:0] r_status;
    logic [7:0] r_char;
    logic r_last;
    logic [15:0] r_cell;
    logic r_we;
    logic [CELL_W-1:0] r_wa, rd_addr;
    logic [15:0] r_wd;
    logic [CELL_W:0] fill_n;
    logic we_set, out_load;

    assign o_job_ready = r_state == S_IDLE && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_line_char = r_char;
    assign o_last      = r_last;
    assign o_cell_value = r_cell;
    assign o_cursor_address = 15'(r_cur) + 15'(i_screen_base);

    // cells to fill: one for a put, rest of the row for a newline
    assign fill_n = (r_job.op == OP_NEWLINE)
                    ? (CELL_W+1)'(COLUMNS_PER_ROW) - (CELL_W+1)'(r_col)
                    : (CELL_W+1)'(1);

    // states that write one cell, and states that load the result
    assign we_set   = r_state == S_SCR_WR || r_state == S_DEL || r_state == S_MARK_WR
                      || (r_state == S_CLR && (r_end == '0 || r_ptr != r_end));
    assign out_load = (r_state == S_EMIT || r_state == S_OUT) && (!r_out_valid || i_ready);

    // read address for the single memory port
    always_comb begin
        rd_addr = r_ptr;
        if (r_state == S_SCR_RD) rd_addr = r_ptr + CELL_W'(COLUMNS_PER_ROW);
    end

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_wa] <= r_wd;
        r_rd <= r_mem[rd_addr];
    end

    // sequencer: every screen job walks the memory one cell a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_we        <= 1'b0;
        end else begin
            r_we <= we_set;
            if (out_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid && o_job_ready) begin
                        r_job  <= i_job;
                        r_emit <= '0;
                        unique case (i_job.op)
                            OP_BEGIN: begin r_ptr <= r_cur; r_state <= S_MARK_RD; end
                            OP_PUT, OP_NEWLINE: r_state <= S_FILL;
                            OP_DELETE: r_state <= S_DEL;
                            OP_READ: begin r_ptr <= i_job.index; r_state <= S_READ_RD; end
                            default: r_state <= i_job.flush ? S_EMIT : S_OUT;
                        endcase
                        r_cell <= '0;
                    end
                end
                S_FILL: begin
                    // decide whether a scroll comes first
                    if ((CELL_W+1)'(r_cur) + fill_n >= (CELL_W+1)'(TOTAL_CELLS)) begin
                        r_ptr   <= '0;
                        r_state <= S_SCR_RD;
                    end else begin
                        r_pos   <= r_cur;
                        r_ptr   <= r_cur;
                        r_end   <= CELL_W'((CELL_W+1)'(r_cur) + fill_n);
                        r_state <= S_CLR;
                    end
                end
                S_SCR_RD: r_state <= S_SCR_WR;
                S_SCR_WR: begin
                    r_wa <= r_ptr;
                    r_wd <= r_rd;
                    if (r_ptr == CELL_W'(TOTAL_CELLS - COLUMNS_PER_ROW - 1)) begin
                        r_ptr <= r_ptr + 1'b1;
                        r_pos <= (r_cur >= CELL_W'(COLUMNS_PER_ROW))
                                 ? r_cur - CELL_W'(COLUMNS_PER_ROW) : '0;
                        r_end <= '0;
                        r_state <= S_CLR;
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_SCR_RD;
                    end
                end
                S_CLR: begin
                    // r_end zero marks the bottom-row clear after a scroll
                    if (r_end == '0) begin
                        r_wa <= r_ptr;
                        r_wd <= '0;
                        if (r_ptr == CELL_W'(TOTAL_CELLS - 1)) begin
                            r_ptr <= r_pos;
                            r_end <= CELL_W'((CELL_W+1)'(r_pos) + fill_n
                                     >= (CELL_W+1)'(TOTAL_CELLS)
                                     ? (CELL_W+1)'(TOTAL_CELLS - 1)
                                     : (CELL_W+1)'(r_pos) + fill_n);
                            r_cur <= r_pos; // same column, one row up
                            r_state <= S_CLR;
                        end else r_ptr <= r_ptr + 1'b1;
                    end else if (r_ptr != r_end) begin
                        r_wa <= r_ptr;
                        r_wd <= (r_job.op == OP_NEWLINE) ? 16'h0000 : r_job.value;
                        r_ptr <= r_ptr + 1'b1;
                    end else begin
                        r_cur   <= r_end;
                        r_col   <= (r_job.op == OP_NEWLINE
                                    || r_col == COL_W'(COLUMNS_PER_ROW - 1))
                                   ? '0 : r_col + 1'b1;
                        r_ptr   <= r_end;
                        r_state <= S_MARK_RD;
                    end
                end
                S_DEL: begin
                    r_wa <= (r_cur != '0) ? r_cur - 1'b1 : '0;
                    r_wd <= {ATTR_N, 8'h00};
                    // the cell after the cleared one takes the cursor attribute
                    r_ptr <= (r_cur != '0) ? r_cur : CELL_W'(1);
                    if (r_cur != '0) begin
                        r_cur <= r_cur - 1'b1;
                        r_col <= (r_col == '0) ? COL_W'(COLUMNS_PER_ROW - 1) : r_col - 1'b1;
                    end
                    r_state <= S_MARK_RD;
                end
                S_MARK_RD: r_state <= S_MARK_WR;
                S_MARK_WR: begin
                    r_wa <= r_ptr;
                    r_wd <= {ATTR_N, r_rd[7:0]};
                    r_state <= r_job.flush ? S_EMIT : S_OUT;
                end
                S_READ_RD: r_state <= S_READ_WAIT;
                S_READ_WAIT: begin
                    r_cell  <= r_rd;
                    r_state <= S_OUT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_status <= ST_LINE;
                        r_char   <= i_line_store[r_emit[LINE_IDX_W-1:0]];
                        r_last   <= r_emit + 1'b1 == r_job.flush_n;
                        r_cell   <= '0;
                        r_emit   <= r_emit + 1'b1;
                        if (r_emit + 1'b1 == r_job.flush_n) r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_status <= r_job.status;
                        r_char   <= '0;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/text_console_line_editor_core.sv @@
`timescale 1ns / 1ps
// A scroll walks all cells through the screen memory's single read port, reading and
// then writing each cell, while a newline fill writes each of its cells once.
// Throughput: one item at a time in the back end; the front queue holds one more.
// Line results stream one per cycle with i_ready high. Synchronous active-low reset
// clears cursor, request and queue; screen and line store are undefined until written.
module text_console_line_editor_core
    import tcle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [13:0] i_cfg_data,
    input  logic i_valid,
    output logic o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_key_code,
    input  logic [6:0] i_request_size,
    input  logic [7:0] i_cell_char,
    input  logic [7:0] i_cell_attr,
    input  logic [10:0] i_cell_index,
    output logic o_valid,
    input  logic i_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_line_char,
    output logic o_last,
    output logic [14:0] o_cursor_address,
    output logic [15:0] o_cell_value
);
    logic [13:0] r_base;
    logic job_valid, job_ready;
    t_job job;
    logic [7:0] line_store [LINE_MAX];

    assign o_cfg_ready = 1'b1;

    // hold the page base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base <= '0;
        else if (i_cfg_valid) r_base <= i_cfg_data;
    end

    tcle_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_key_code, .i_request_size,
        .i_cell_char, .i_cell_attr, .i_cell_index,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job),
        .o_line_store(line_store)
    );

    tcle_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready),
        .i_job(job), .i_line_store(line_store), .i_screen_base(r_base),
        .o_valid, .i_ready, .o_status, .o_line_char, .o_last,
        .o_cursor_address, .o_cell_value
    );
endmodule

@@ rtl/tcle_checker.sv @@
`timescale 1ns / 1ps
module tcle_checker
    import tcle_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic [1:0] o_status,
    input logic [7:0] o_line_char,
    input logic o_last,
    input logic [15:0] o_cell_value
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)) else $error("output dropped");
    a_line_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_LINE |-> o_cell_value == 16'h0) else $error("line cell");
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_LINE |-> o_line_char == 8'h0 && o_last) else $error("reply");
endmodule

bind text_console_line_editor_core tcle_checker u_chk (.*);
